>>> design/fca_pkg.sv
// shared constants, codes and transfer types for the link table allocator
package fca_pkg;

  // table geometry
  localparam int unsigned MAX_ENTRIES = 4096;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned LIM_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned BLK_W       = 16;
  localparam int unsigned CNT_W       = 13;
  // wide enough for any block index and for the limit itself
  localparam int unsigned CMP_W       = BLK_W + 1;

  localparam logic [BLK_W-1:0] LINK_FREE  = '0;
  localparam logic [BLK_W-1:0] LINK_END   = '1;
  localparam logic [BLK_W-1:0] FIRST_DATA = BLK_W'(2);

  localparam logic [CNT_W-1:0] ENTRY_COUNT_RST = CNT_W'(4096);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_NOT_MOUNTED = 3'd2,
    ST_RANGE       = 3'd3,
    ST_TOO_LONG    = 3'd4
  } status_e;

  // next value of the walk / scan pointer
  typedef enum logic [1:0] {
    CUR_HOLD = 2'd0,
    CUR_ITEM = 2'd1,
    CUR_INC  = 2'd2,
    CUR_LINK = 2'd3
  } cur_op_e;

  // table write data select
  typedef enum logic [1:0] {
    WD_FREE = 2'd0,
    WD_END  = 2'd1,
    WD_ITEM = 2'd2
  } wsel_e;

  // result block select
  typedef enum logic [1:0] {
    RES_NONE  = 2'd0,
    RES_CUR   = 2'd1,
    RES_RDATA = 2'd2
  } res_src_e;

  typedef struct packed {
    opcode_e          opcode;
    logic [BLK_W-1:0] block;
    logic [BLK_W-1:0] link_value;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [BLK_W-1:0] result_block;
  } out_item_t;

  typedef struct packed {
    logic     item_load;
    cur_op_e  cur_op;
    logic     steps_clr;
    logic     steps_inc;
    logic     mem_re;
    logic     mem_we;
    wsel_e    wsel;
    logic     res_set;
    status_e  res_status;
    res_src_e res_src;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic cur_ge_lim;
    logic cur_term;
    logic steps_ge_lim;
    logic rdata_free;
    logic clr_last;
  } dp_stat_t;

endpackage

>>> design/fca_datapath.sv
// link table memory, scan/walk pointer, step counter and result registers
module fca_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fca_pkg::dp_cmd_t           cmd_i,
  output fca_pkg::dp_stat_t          stat_o,
  input  fca_pkg::in_item_t          in_data_i,
  input  logic [fca_pkg::CNT_W-1:0]  entry_count_i,
  output fca_pkg::out_item_t         out_data_o
);
  import fca_pkg::*;

  logic [BLK_W-1:0] mem [MAX_ENTRIES];
  logic [BLK_W-1:0] mem_rdata_q;
  logic [BLK_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_addr;

  logic [CMP_W-1:0] cur_q, cur_d;
  logic [LIM_W-1:0] steps_q, steps_d;
  logic [CMP_W-1:0] lim;
  logic [CMP_W-1:0] cnt_ext;

  logic [BLK_W-1:0] link_q;
  status_e          res_status_q;
  logic [BLK_W-1:0] res_block_q;
  out_item_t        out_q;

  // usable limit is the smaller of entry count and table depth
  assign cnt_ext = CMP_W'(entry_count_i);
  assign lim     = (cnt_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cnt_ext;

  always_comb begin
    unique case (cmd_i.cur_op)
      CUR_HOLD: cur_d = cur_q;
      CUR_ITEM: cur_d = (in_data_i.opcode == OP_ALLOC) ? CMP_W'(FIRST_DATA)
                                                        : CMP_W'(in_data_i.block);
      CUR_INC:  cur_d = cur_q + CMP_W'(1);
      CUR_LINK: cur_d = CMP_W'(mem_rdata_q);
    endcase
  end

  always_comb begin
    steps_d = steps_q;
    if (cmd_i.steps_clr) begin
      steps_d = '0;
    end else if (cmd_i.steps_inc) begin
      steps_d = steps_q + LIM_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      steps_q <= '0;
    end else begin
      cur_q   <= cur_d;
      steps_q <= steps_d;
    end
  end

  assign mem_addr = cur_q[IDX_W-1:0];

  always_comb begin
    case (cmd_i.wsel)
      WD_FREE: mem_wdata = LINK_FREE;
      WD_END:  mem_wdata = LINK_END;
      WD_ITEM: mem_wdata = link_q;
      default: mem_wdata = LINK_FREE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd_i.mem_re) begin
      mem_rdata_q <= mem[mem_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      link_q <= in_data_i.link_value;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      case (cmd_i.res_src)
        RES_CUR:   res_block_q <= cur_q[BLK_W-1:0];
        RES_RDATA: res_block_q <= mem_rdata_q;
        default:   res_block_q <= '0;
      endcase
    end
    if (cmd_i.out_load) begin
      out_q.status       <= res_status_q;
      out_q.result_block <= res_block_q;
    end
  end

  assign out_data_o = out_q;

  assign stat_o.cur_ge_lim   = (cur_q >= lim);
  assign stat_o.cur_term     = (cur_q == CMP_W'(LINK_FREE)) || (cur_q == CMP_W'(LINK_END));
  assign stat_o.steps_ge_lim = (CMP_W'(steps_q) >= lim);
  assign stat_o.rdata_free   = (mem_rdata_q == LINK_FREE);
  assign stat_o.clr_last     = (mem_addr == IDX_W'(MAX_ENTRIES - 1));

endmodule

>>> design/fca_ctrl.sv
// sequencing state machine: clearing pass, scan, chain walk, link access
module fca_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fca_pkg::opcode_e   in_opcode_i,
  input  logic               mounted_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fca_pkg::dp_cmd_t   cmd_o,
  input  fca_pkg::dp_stat_t  stat_i
);
  import fca_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_A_RD   = 4'd2;
  localparam logic [3:0] S_A_CHK  = 4'd3;
  localparam logic [3:0] S_F_TST  = 4'd4;
  localparam logic [3:0] S_F_WR   = 4'd5;
  localparam logic [3:0] S_R_RD   = 4'd6;
  localparam logic [3:0] S_R_DATA = 4'd7;
  localparam logic [3:0] S_W_WR   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d          = state_q;
    out_valid_d      = out_valid_q && !out_ready_i;
    in_ready_o       = 1'b0;
    cmd_o.item_load  = 1'b0;
    cmd_o.cur_op     = CUR_HOLD;
    cmd_o.steps_clr  = 1'b0;
    cmd_o.steps_inc  = 1'b0;
    cmd_o.mem_re     = 1'b0;
    cmd_o.mem_we     = 1'b0;
    cmd_o.wsel       = WD_FREE;
    cmd_o.res_set    = 1'b0;
    cmd_o.res_status = ST_OK;
    cmd_o.res_src    = RES_NONE;
    cmd_o.out_load   = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wsel   = WD_FREE;
        cmd_o.cur_op = CUR_INC;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          cmd_o.cur_op    = CUR_ITEM;
          cmd_o.steps_clr = 1'b1;
          unique case (in_opcode_i)
            OP_ALLOC: state_d = S_A_RD;
            OP_FREE: begin
              if (mounted_i) begin
                state_d = S_F_TST;
              end else begin
                cmd_o.res_set    = 1'b1;
                cmd_o.res_status = ST_NOT_MOUNTED;
                state_d          = S_DONE;
              end
            end
            OP_READ:  state_d = S_R_RD;
            OP_WRITE: state_d = S_W_WR;
          endcase
        end
      end
      S_A_RD: begin
        if (stat_i.cur_ge_lim) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_FULL;
          state_d          = S_DONE;
        end else begin
          cmd_o.mem_re = 1'b1;
          state_d      = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (stat_i.rdata_free) begin
          cmd_o.mem_we     = 1'b1;
          cmd_o.wsel       = WD_END;
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_OK;
          cmd_o.res_src    = RES_CUR;
          state_d          = S_DONE;
        end else begin
          cmd_o.cur_op = CUR_INC;
          state_d      = S_A_RD;
        end
      end
      S_F_TST: begin
        priority if (stat_i.cur_term) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_OK;
          state_d          = S_DONE;
        end else if (stat_i.cur_ge_lim) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_RANGE;
          state_d          = S_DONE;
        end else if (stat_i.steps_ge_lim) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_TOO_LONG;
          state_d          = S_DONE;
        end else begin
          cmd_o.mem_re = 1'b1;
          state_d      = S_F_WR;
        end
      end
      S_F_WR: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.wsel      = WD_FREE;
        cmd_o.cur_op    = CUR_LINK;
        cmd_o.steps_inc = 1'b1;
        state_d         = S_F_TST;
      end
      S_R_RD: begin
        if (stat_i.cur_ge_lim) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_RANGE;
          state_d          = S_DONE;
        end else begin
          cmd_o.mem_re = 1'b1;
          state_d      = S_R_DATA;
        end
      end
      S_R_DATA: begin
        cmd_o.res_set    = 1'b1;
        cmd_o.res_status = ST_OK;
        cmd_o.res_src    = RES_RDATA;
        state_d          = S_DONE;
      end
      S_W_WR: begin
        cmd_o.res_set = 1'b1;
        if (stat_i.cur_ge_lim) begin
          cmd_o.res_status = ST_RANGE;
        end else begin
          cmd_o.mem_we     = 1'b1;
          cmd_o.wsel       = WD_ITEM;
          cmd_o.res_status = ST_OK;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // one item in flight: after an input transfer, no new one is taken next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an item is still in progress");

  // output register is only reloaded once its previous result has left
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  // the table port is either read or written in one cycle
  a_one_port_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.mem_re && cmd_o.mem_we))
    else $error("table read and write in the same cycle");

  // nothing is accepted during the clearing pass
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (!in_ready_o && !cmd_o.mem_re))
    else $error("activity during clearing pass");

endmodule

>>> design/fat_chain_allocator.sv
// top level: link table allocator with its register port, controller and datapath
//
// Keeps a table of 16-bit links (0 free, 0xFFFF end of chain) in a single-port
// memory of MAX_ENTRIES words and serves one request at a time: allocate the
// first free entry from index 2 upward, free a whole chain, read one link or
// write one link. Every accepted request gives exactly one result transfer.
// After reset the block runs a clearing pass over all MAX_ENTRIES words that
// zeroes the table; in_ready_o stays low during it, while register writes are
// taken as usual. Timing is set by the memory port, which does one read or one
// write per cycle with registered read data. Allocate reads the scanned entries
// one by one until it finds a free one or reaches the limit; free chain reads
// each link and clears it while walking the chain. The finished result lands in
// the output register and waits there, and the next request is accepted while
// it waits; a later result is held back until the waiting one has left, so
// out_ready_i stalls delay it. The user must write entry_count and mounted
// through the register port only while no request is in progress; the block
// itself does not enforce this.
module fat_chain_allocator (
  input  logic                clk_i,
  input  logic                rst_ni,

  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fca_pkg::in_item_t   in_data_i,

  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fca_pkg::out_item_t  out_data_o,

  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import fca_pkg::*;

  // register index decode (byte address bit 2)
  localparam logic REG_ENTRY_COUNT = 1'b0;
  localparam logic REG_MOUNTED     = 1'b1;

  logic [CNT_W-1:0] entry_count_q;
  logic             mounted_q;
  logic             cfg_we;
  logic             reg_sel;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // register write on the access phase
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= ENTRY_COUNT_RST;
      mounted_q     <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_ENTRY_COUNT: entry_count_q <= pwdata[CNT_W-1:0];
        REG_MOUNTED:     mounted_q     <= pwdata[0];
      endcase
    end
  end

  // register readback; low address bits are don't-care
  always_comb begin
    unique case (reg_sel)
      REG_ENTRY_COUNT: prdata = 32'(entry_count_q);
      REG_MOUNTED:     prdata = 32'(mounted_q);
    endcase
  end

  // sequencing: clearing pass, allocate scan, chain walk, single link access
  fca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_opcode_i (in_data_i.opcode),
    .mounted_i   (mounted_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  // table memory, pointer, step count and output register
  fca_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .in_data_i     (in_data_i),
    .entry_count_i (entry_count_q),
    .out_data_o    (out_data_o)
  );

endmodule

>>> sim/fat_chain_allocator_tb.sv
// testbench for the link table allocator: directed rows, then random request phases
module fat_chain_allocator_tb;
  import fca_pkg::*;

  // register port addresses
  localparam logic [2:0] REG_ENTRY_COUNT = 3'd0;
  localparam logic [2:0] REG_MOUNTED     = 3'd4;

  // entry counts of the random phases, smallest and largest among them
  localparam int unsigned PHASE_COUNT [11] = '{16, 3, 4, 5, 9, 4096, 32, 64, 24, 200, 12};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  out_item_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  fat_chain_allocator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // one row of the directed part: a register write or a request
  typedef struct {
    bit          cfg;
    logic [2:0]  addr;
    logic [31:0] wdata;
    in_item_t    req;
    bit          pinned;
    out_item_t   want;
  } stim_row_t;

  stim_row_t        plan_q[$];
  out_item_t        result_q[$];
  logic [BLK_W-1:0] link_mem [MAX_ENTRIES];
  int unsigned      cfg_entry_count;
  bit               cfg_mounted;
  bit               tx_idle_on;
  bit               rx_idle_on;
  int unsigned      rx_wait = 0;
  int unsigned      err_cnt = 0;

  function automatic int unsigned table_limit();
    return (cfg_entry_count > MAX_ENTRIES) ? MAX_ENTRIES : cfg_entry_count;
  endfunction

  // expected result of one request, applied to the local copy of the table
  function automatic out_item_t predict_request(input in_item_t req);
    out_item_t        res;
    int unsigned      lim;
    int unsigned      steps;
    logic [BLK_W-1:0] cur;
    logic [BLK_W-1:0] nxt;
    lim = table_limit();
    res = '{status: ST_OK, result_block: '0};
    case (req.opcode)
      OP_ALLOC: begin
        res.status = ST_FULL;
        for (int unsigned i = FIRST_DATA; i < lim; i++) begin
          if (link_mem[i] == LINK_FREE) begin
            link_mem[i] = LINK_END;
            res = '{status: ST_OK, result_block: BLK_W'(i)};
            break;
          end
        end
      end
      OP_FREE: begin
        cur   = req.block;
        steps = 0;
        if (!cfg_mounted) begin
          res.status = ST_NOT_MOUNTED;
        end else begin
          // each visited entry is cleared, so a loop ends on a freed entry
          while (cur != LINK_FREE && cur != LINK_END) begin
            if (cur >= lim) begin
              res.status = ST_RANGE;
              break;
            end
            if (steps >= lim) begin
              res.status = ST_TOO_LONG;
              break;
            end
            nxt           = link_mem[cur];
            link_mem[cur] = LINK_FREE;
            cur           = nxt;
            steps++;
          end
        end
      end
      OP_READ: begin
        if (req.block >= lim) res.status = ST_RANGE;
        else res.result_block = link_mem[req.block];
      end
      default: begin
        if (req.block >= lim) res.status = ST_RANGE;
        else link_mem[req.block] = req.link_value;
      end
    endcase
    return res;
  endfunction

  function automatic void note_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch: %s", what);
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (result_q.size() == 0) begin
      note_mismatch($sformatf("result with none pending: status %0d block %h",
                              got.status, got.result_block));
      return;
    end
    want = result_q.pop_front();
    if (got.status !== want.status)
      note_mismatch($sformatf("status: expected %0d, got %0d", want.status, got.status));
    if (got.result_block !== want.result_block)
      note_mismatch($sformatf("result_block: expected %h, got %h",
                              want.result_block, got.result_block));
  endtask

  // result side: check each transfer, then hold ready low for a drawn number of cycles
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      check_result(out_data_o);
      rx_wait = rx_idle_on ? $urandom_range(0, 8) : 0;
      out_ready_i <= (rx_wait == 0);
    end else if (out_valid_o && rx_wait != 0) begin
      rx_wait--;
      out_ready_i <= (rx_wait == 0);
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_ENTRY_COUNT) cfg_entry_count = data[CNT_W-1:0];
    else if (addr == REG_MOUNTED) cfg_mounted = data[0];
    // the bus returns to idle before the next setup phase
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  // request side: optional gap, then hold valid until the transfer
  task automatic send_request(input in_item_t req, input bit pinned, input out_item_t want);
    int unsigned gap;
    out_item_t   pred;
    gap = tx_idle_on ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    pred = predict_request(req);
    result_q.push_back(pinned ? want : pred);
  endtask

  task automatic send_op(input opcode_e op, input logic [15:0] blk, input logic [15:0] val);
    in_item_t req;
    req = '{opcode: op, block: blk, link_value: val};
    send_request(req, 1'b0, '0);
  endtask

  function automatic void add_cfg(input logic [2:0] addr, input logic [31:0] data);
    stim_row_t row;
    row       = '{default: '0};
    row.cfg   = 1'b1;
    row.addr  = addr;
    row.wdata = data;
    plan_q.push_back(row);
  endfunction

  function automatic void add_req(input opcode_e op, input logic [15:0] blk,
                                  input logic [15:0] val);
    stim_row_t row;
    row     = '{default: '0};
    row.req = '{opcode: op, block: blk, link_value: val};
    plan_q.push_back(row);
  endfunction

  function automatic void add_pinned(input opcode_e op, input logic [15:0] blk,
                                     input logic [15:0] val, input status_e st,
                                     input logic [15:0] res);
    stim_row_t row;
    row        = '{default: '0};
    row.req    = '{opcode: op, block: blk, link_value: val};
    row.pinned = 1'b1;
    row.want   = '{status: st, result_block: res};
    plan_q.push_back(row);
  endfunction

  // chain member inside the table, now and then entry 1
  function automatic logic [15:0] pick_index(input int unsigned lim);
    if ($urandom_range(0, 15) == 0) return 16'd1;
    return 16'($urandom_range(FIRST_DATA, lim - 1));
  endfunction

  function automatic logic [15:0] rand_block(input int unsigned lim);
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'(lim - 1 + $urandom_range(0, 2));
      default: return 16'($urandom_range(0, lim - 1));
    endcase
  endfunction

  function automatic logic [15:0] rand_link(input int unsigned lim);
    case ($urandom_range(0, 4))
      0:       return LINK_FREE;
      1:       return LINK_END;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, lim - 1));
    endcase
  endfunction

  task automatic run_random_phase(input int unsigned budget);
    int unsigned      sent;
    int unsigned      lim;
    int unsigned      n;
    logic [BLK_W-1:0] head;
    logic [BLK_W-1:0] prev;
    logic [BLK_W-1:0] nxt;
    logic [BLK_W-1:0] tail;
    lim  = table_limit();
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) < 6) begin
        // up to two allocations, then a chain threaded by writes, sometimes a read, and a free from its head
        repeat ($urandom_range(0, 2)) begin
          send_op(OP_ALLOC, 16'($urandom), 16'($urandom));
          sent++;
        end
        n    = $urandom_range(1, 6);
        head = pick_index(lim);
        prev = head;
        repeat (n - 1) begin
          nxt = pick_index(lim);
          send_op(OP_WRITE, prev, nxt);
          prev = nxt;
          sent++;
        end
        case ($urandom_range(0, 5))
          0:       tail = 16'($urandom);
          1:       tail = head;
          default: tail = LINK_END;
        endcase
        send_op(OP_WRITE, prev, tail);
        if ($urandom_range(0, 2) == 0) begin
          send_op(OP_READ, pick_index(lim), 16'($urandom));
          sent++;
        end
        send_op(OP_FREE, head, 16'($urandom));
        sent += 2;
      end else begin
        send_op(opcode_e'(2'($urandom_range(0, 3))), rand_block(lim), rand_link(lim));
        sent++;
      end
    end
  endtask

  initial begin
    foreach (link_mem[i]) link_mem[i] = LINK_FREE;
    cfg_entry_count = ENTRY_COUNT_RST;
    cfg_mounted     = 1'b0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;

    // full table size, not mounted
    add_cfg(REG_ENTRY_COUNT, 32'd4096);
    add_cfg(REG_MOUNTED, 32'd0);
    add_pinned(OP_READ, 16'd0, 16'd0, ST_OK, 16'd0);
    add_pinned(OP_READ, 16'd4095, 16'hFFFF, ST_OK, 16'd0);
    add_pinned(OP_READ, 16'd4096, 16'd0, ST_RANGE, 16'd0);
    add_pinned(OP_READ, 16'hFFFF, 16'd0, ST_RANGE, 16'd0);
    add_pinned(OP_WRITE, 16'd4096, 16'd1234, ST_RANGE, 16'd0);
    add_pinned(OP_WRITE, 16'hFFFF, 16'hFFFF, ST_RANGE, 16'd0);
    add_pinned(OP_FREE, 16'd2, 16'd0, ST_NOT_MOUNTED, 16'd0);
    add_pinned(OP_ALLOC, 16'd0, 16'd0, ST_OK, 16'd2);
    add_pinned(OP_ALLOC, 16'hFFFF, 16'hFFFF, ST_OK, 16'd3);
    add_pinned(OP_READ, 16'd2, 16'd0, ST_OK, LINK_END);
    add_pinned(OP_WRITE, 16'd0, 16'hFFFF, ST_OK, 16'd0);
    add_pinned(OP_WRITE, 16'd1, 16'h5555, ST_OK, 16'd0);
    add_pinned(OP_READ, 16'd1, 16'd0, ST_OK, 16'h5555);
    add_req(OP_WRITE, 16'd4095, 16'hAAAA);
    // mounted: chain 2 -> 3 -> 4095 -> out of range
    add_cfg(REG_MOUNTED, 32'd1);
    add_req(OP_WRITE, 16'd2, 16'd3);
    add_req(OP_WRITE, 16'd3, 16'd4095);
    add_pinned(OP_FREE, 16'd2, 16'd0, ST_RANGE, 16'd0);
    add_req(OP_READ, 16'd4095, 16'd0);
    add_pinned(OP_FREE, LINK_FREE, 16'd0, ST_OK, 16'd0);
    add_pinned(OP_FREE, LINK_END, 16'd0, ST_OK, 16'd0);
    add_pinned(OP_FREE, 16'd4096, 16'd0, ST_RANGE, 16'd0);
    // two entries linked in a loop
    add_req(OP_WRITE, 16'd5, 16'd6);
    add_req(OP_WRITE, 16'd6, 16'd5);
    add_req(OP_FREE, 16'd5, 16'd0);
    // smallest table: only entry 2 can be allocated
    add_cfg(REG_ENTRY_COUNT, 32'd3);
    add_req(OP_WRITE, 16'd2, LINK_END);
    add_pinned(OP_ALLOC, 16'd0, 16'd0, ST_FULL, 16'd0);
    add_pinned(OP_READ, 16'd3, 16'd0, ST_RANGE, 16'd0);
    add_req(OP_FREE, 16'd2, 16'd0);
    add_req(OP_ALLOC, 16'd0, 16'd0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows; register writes wait for the block to go idle
    foreach (plan_q[r]) begin
      if (plan_q[r].cfg) begin
        in_valid_i <= 1'b0;
        wait_drained();
        reg_write(plan_q[r].addr, plan_q[r].wdata);
      end else begin
        send_request(plan_q[r].req, plan_q[r].pinned, plan_q[r].want);
      end
    end

    // random phases, each with its own size, mount state and idling mix
    foreach (PHASE_COUNT[p]) begin
      in_valid_i <= 1'b0;
      wait_drained();
      tx_idle_on = (p != 0) && (p % 3 != 1);
      rx_idle_on = (p != 0) && (p % 3 != 2);
      reg_write(REG_ENTRY_COUNT, PHASE_COUNT[p]);
      reg_write(REG_MOUNTED, 32'((p % 4) != 2));
      run_random_phase((PHASE_COUNT[p] == MAX_ENTRIES) ? 30 : 160);
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // a hung handshake ends the run here
  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> fat_chain_allocator.f
design/fca_pkg.sv
design/fca_datapath.sv
design/fca_ctrl.sv
design/fat_chain_allocator.sv
sim/fat_chain_allocator_tb.sv
